[rtl/met_pkg.sv]
// Shared types, constants and helpers for the escape-time pixel evaluator.
package met_pkg;

    // Fixed-point format: signed Q4.28
    localparam int unsigned FRAC_BITS = 28;

    // |z|^2 escape bound, 4.0 in Q8.56
    localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

    // Point queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic signed [31:0] ORIGIN_REAL_RST = 32'shE000_0000;
    localparam logic signed [31:0] ORIGIN_IMAG_RST = 32'shE800_0000;
    localparam logic [28:0]        STEP_REAL_RST   = 29'd786432;
    localparam logic [28:0]        STEP_IMAG_RST   = 29'd786432;
    localparam logic [11:0]        MAX_ITER_RST    = 12'd250;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN_REAL = 3'd0,
        CFG_ORIGIN_IMAG = 3'd1,
        CFG_STEP_REAL   = 3'd2,
        CFG_STEP_IMAG   = 3'd3,
        CFG_MAX_ITER    = 3'd4
    } cfg_index_t;

    // Input beat
    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } pixel_t;

    // Result beat
    typedef struct packed {
        logic [11:0] iteration_count;
        logic        inside_set;
        logic [7:0]  gray_level;
    } result_t;

    // Point c handed from front to back
    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
    } point_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Saturate a signed 64-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v[63:31] != {33{v[63]}})
        begin
            r = v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/mandelbrot_escape_time_pixel.sv]
// Top level of the escape-time pixel evaluator.
// Path: the front end registers coordinate times step, adds the origin and pushes c
//   into the queue; the back end pops it, runs a multiply/update loop per iteration and,
//   for an escaped point, a restoring gray divider; done and result are registered.
//   A four-entry point queue lets the front end keep accepting, while it has room, as the back end iterates.
// Reset: rst_n clears the queue, both sequencers and loads the register defaults.
module mandelbrot_escape_time_pixel #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  met_pkg::pixel_t   pixel,
    output logic              done,
    output met_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    logic signed [31:0]     origin_real_reg;
    logic signed [31:0]     origin_imag_reg;
    logic [28:0]            step_real_reg;
    logic [28:0]            step_imag_reg;
    logic [11:0]            max_iter_reg;

    logic                   push;
    logic                   pop;
    met_pkg::point_t        push_point;
    met_pkg::point_t        head_point;
    met_pkg::queue_status_t q_status;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_real_reg <= met_pkg::ORIGIN_REAL_RST;
            origin_imag_reg <= met_pkg::ORIGIN_IMAG_RST;
            step_real_reg   <= met_pkg::STEP_REAL_RST;
            step_imag_reg   <= met_pkg::STEP_IMAG_RST;
            max_iter_reg    <= met_pkg::MAX_ITER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                met_pkg::CFG_ORIGIN_REAL: origin_real_reg <= cfg_data;
                met_pkg::CFG_ORIGIN_IMAG: origin_imag_reg <= cfg_data;
                met_pkg::CFG_STEP_REAL:   step_real_reg   <= cfg_data[28:0];
                met_pkg::CFG_STEP_IMAG:   step_imag_reg   <= cfg_data[28:0];
                met_pkg::CFG_MAX_ITER:    max_iter_reg    <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    met_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .pixel       (pixel),
        .origin_real (origin_real_reg),
        .origin_imag (origin_imag_reg),
        .step_real   (step_real_reg),
        .step_imag   (step_imag_reg),
        .q_status    (q_status),
        .busy        (busy),
        .push        (push),
        .point       (push_point)
    );

    met_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_point (push_point),
        .pop        (pop),
        .head_point (head_point),
        .status     (q_status)
    );

    met_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_iterations (max_iter_reg),
        .q_status       (q_status),
        .head_point     (head_point),
        .pop            (pop),
        .done           (done),
        .result         (result)
    );

endmodule

[rtl/met_front.sv]
// Front end: accepts a pixel, clamps it and forms the point c.
module met_front #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  met_pkg::pixel_t       pixel,
    input  logic signed [31:0]    origin_real,
    input  logic signed [31:0]    origin_imag,
    input  logic [28:0]           step_real,
    input  logic [28:0]           step_imag,
    input  met_pkg::queue_status_t q_status,
    output logic                  busy,
    output logic                  push,
    output met_pkg::point_t       point
);

    localparam logic [12:0] X_LAST = 13'(IMAGE_WIDTH - 1);
    localparam logic [12:0] Y_LAST = 13'(IMAGE_HEIGHT - 1);

    logic              prod_valid_reg;
    logic              prod_valid_next;
    logic [38:0]       prod_re_reg;
    logic [38:0]       prod_im_reg;
    logic [9:0]        px_clamped;
    logic [9:0]        py_clamped;
    logic              accept;
    logic signed [40:0] sum_re;
    logic signed [40:0] sum_im;

    // One item in flight; the queue always has room when it lands
    assign busy   = prod_valid_reg | q_status.full;
    assign accept = start & ~busy;

    // Clamp coordinates to the image
    assign px_clamped = ({3'b000, pixel.pixel_x} > X_LAST) ? X_LAST[9:0] : pixel.pixel_x;
    assign py_clamped = ({3'b000, pixel.pixel_y} > Y_LAST) ? Y_LAST[9:0] : pixel.pixel_y;

    assign prod_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    // Coordinate times step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_re_reg <= 39'(px_clamped) * 39'(step_real);
            prod_im_reg <= 39'(py_clamped) * 39'(step_imag);
        end
    end

    // Add origin and saturate, pushed the cycle after accept
    assign sum_re = 41'(origin_real) + $signed({2'b00, prod_re_reg});
    assign sum_im = 41'(origin_imag) + $signed({2'b00, prod_im_reg});

    assign push         = prod_valid_reg;
    assign point.c_real = met_pkg::sat32(64'(sum_re));
    assign point.c_imag = met_pkg::sat32(64'(sum_im));

endmodule

[rtl/met_queue.sv]
// Short FIFO of points between the front end and the iteration engine.
module met_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  met_pkg::point_t        push_point,
    input  logic                   pop,
    output met_pkg::point_t        head_point,
    output met_pkg::queue_status_t status
);

    localparam int unsigned DEPTH = met_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = met_pkg::QUEUE_PTR_W;
    localparam int unsigned CNT_W = met_pkg::QUEUE_CNT_W;

    met_pkg::point_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign head_point   = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_point;
        end
    end

endmodule

[rtl/met_back.sv]
// Back end: z = z*z + c iteration engine and gray-level divider.
module met_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [11:0]            max_iterations,
    input  met_pkg::queue_status_t q_status,
    input  met_pkg::point_t        head_point,
    output logic                   pop,
    output logic                   done,
    output met_pkg::result_t       result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_UPD  = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               done_reg;
    logic               done_next;
    met_pkg::result_t   result_reg;
    met_pkg::result_t   result_next;

    logic signed [31:0] cr_reg, cr_next;
    logic signed [31:0] ci_reg, ci_next;
    logic signed [31:0] zr_reg, zr_next;
    logic signed [31:0] zi_reg, zi_next;
    logic signed [63:0] rr_reg, rr_next;
    logic signed [63:0] ii_reg, ii_next;
    logic signed [63:0] ri_reg, ri_next;
    logic [11:0]        count_reg, count_next;
    logic [19:0]        rem_reg, rem_next;
    logic [7:0]         quo_reg, quo_next;
    logic [2:0]         bit_reg, bit_next;

    logic [11:0]        count_inc;
    logic [63:0]        mag;
    logic               escape;
    logic signed [63:0] diff;
    logic signed [63:0] zr_wide;
    logic signed [63:0] zi_wide;
    logic [19:0]        div_shifted;
    logic [19:0]        count_x255;

    // Squares and cross product, registered before use
    assign rr_next = 64'(zr_reg) * 64'(zr_reg);
    assign ii_next = 64'(zi_reg) * 64'(zi_reg);
    assign ri_next = 64'(zr_reg) * 64'(zi_reg);

    // Escape test and update datapath
    assign mag        = 64'(unsigned'(rr_reg)) + 64'(unsigned'(ii_reg));
    assign escape     = (mag > met_pkg::ESCAPE_LIMIT);
    assign diff       = rr_reg - ii_reg;
    assign zr_wide    = (diff >>> met_pkg::FRAC_BITS) + 64'(cr_reg);
    assign zi_wide    = (ri_reg >>> (met_pkg::FRAC_BITS - 1)) + 64'(ci_reg);
    assign count_inc  = count_reg + 12'd1;
    assign count_x255 = ({8'd0, count_reg} << 8) - {8'd0, count_reg};
    assign div_shifted = {8'd0, max_iterations} << bit_reg;

    assign pop = (state_reg == S_IDLE) & ~q_status.empty;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        zr_next     = zr_reg;
        zi_next     = zi_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        bit_next    = bit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    cr_next    = head_point.c_real;
                    ci_next    = head_point.c_imag;
                    zr_next    = '0;
                    zi_next    = '0;
                    count_next = '0;
                    if (max_iterations == 12'd0)
                    begin
                        // zero limit: inside with no iteration
                        done_next   = 1'b1;
                        result_next = '{iteration_count: 12'd0, inside_set: 1'b1,
                                        gray_level: 8'd0};
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (escape)
                begin
                    // escaped below the limit: work out the gray level
                    rem_next   = count_x255;
                    quo_next   = '0;
                    bit_next   = 3'd7;
                    state_next = S_DIV;
                end
                else
                begin
                    zr_next    = met_pkg::sat32(zr_wide);
                    zi_next    = met_pkg::sat32(zi_wide);
                    count_next = count_inc;
                    if (count_inc == max_iterations)
                    begin
                        done_next   = 1'b1;
                        result_next = '{iteration_count: count_inc, inside_set: 1'b1,
                                        gray_level: 8'd0};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_reg >= div_shifted)
                begin
                    rem_next           = rem_reg - div_shifted;
                    quo_next[bit_reg]  = 1'b1;
                end
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    done_next   = 1'b1;
                    result_next = '{iteration_count: count_reg, inside_set: 1'b0,
                                    gray_level: quo_next};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        rr_reg     <= rr_next;
        ii_reg     <= ii_next;
        ri_reg     <= ri_next;
        count_reg  <= count_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        bit_reg    <= bit_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/met_checker.sv]
// Port-level assertions for the escape-time pixel evaluator, bound to the top level.
module met_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input met_pkg::result_t result
);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       accept;

    assign accept = start & ~busy;

    // Items accepted but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (accept && !done)
        begin
            pending_next = pending_reg + 4'd1;
        end
        else if (done && !accept)
        begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // No result beat without an item waiting for it
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pending_reg != 4'd0))
        else $error("result beat with no pending item");

    // Front end holds off after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // Inside points are black
    a_inside_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.inside_set) |-> (result.gray_level == 8'd0))
        else $error("inside point with nonzero gray level");

    // Zero iteration count gives gray zero
    a_zero_count_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.iteration_count == 12'd0)) |-> (result.gray_level == 8'd0))
        else $error("zero count with nonzero gray level");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
